/* rtl/cdt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk download tracker package
// Widths, request kinds, status codes and derived sizes shared by the design.
// ----------------------------------------------------------------------------
package cdt_pkg;

    localparam int CHUNK_BYTES     = 256;
    localparam int MAP_BYTES       = 128;
    localparam int MAX_IMAGE_BYTES = 262144;

    localparam int KIND_W   = 2;
    localparam int IDX_W    = 10;
    localparam int LEN_W    = 16;
    localparam int BIDX_W   = 7;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = 21;
    localparam int IMG_W    = 19;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 21;

    // Bitmap geometry.
    localparam int BIT_W       = 3;
    localparam int MAP_AW      = $clog2(MAP_BYTES);
    localparam int CHUNK_SHIFT = $clog2(CHUNK_BYTES);
    localparam int MAX_CHUNKS  = (MAP_BYTES * 8 < 1024) ? MAP_BYTES * 8 : 1024;
    localparam int CNT_W       = $clog2(MAX_CHUNKS + 1);

    localparam logic [KIND_W-1:0] KIND_MARK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SCAN    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESTORE = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PARAM = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_INDEX = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_SIZE  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAGING_BASE = 1'b1;

endpackage

/* rtl/cdt_map_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap RAM
// Simple dual-port synchronous RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module cdt_map_ram #(
    parameter int AW = 7,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [2**AW];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/chunk_download_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk download tracker
// Received-chunk bitmap for a chunked firmware image, with mark, query,
// first-missing scan and bitmap restore requests.
//
// Requests arrive on the in_valid/in_ready channel, one transfer per request,
// and each request gives exactly one result on the out_valid/out_ready channel.
// Registers are written through the cfg_valid/cfg_ready channel, which is
// always ready; write them only while no request is in flight.
// One request is worked on at a time. Restore and rejected requests go
// straight to the result step, mark and query first do one bitmap RAM
// read, then the update or bit pick, and a scan examines one bitmap byte
// at a time until it finds a gap, up to every byte of a full 1024-chunk
// image, since the single RAM read port delivers one byte per cycle.
// A new request is taken as soon as the previous one has moved to the output
// register, even while that result still waits for out_ready; a result waiting
// behind a stalled receiver holds the block in its final step.
// Reset clears both registers, and a per-byte valid flag makes every bitmap
// byte read as zero until it is written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module chunk_download_tracker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [cdt_pkg::KIND_W-1:0]     kind,
    input  logic [cdt_pkg::IDX_W-1:0]      chunk_id,
    input  logic [cdt_pkg::LEN_W-1:0]      length,
    input  logic [cdt_pkg::BIDX_W-1:0]     byte_index,
    input  logic [cdt_pkg::BYTE_W-1:0]     byte_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [cdt_pkg::STATUS_W-1:0]   status,
    output logic [cdt_pkg::ADDR_W-1:0]     write_address,
    output logic                           received,
    output logic                           found,
    output logic [cdt_pkg::IDX_W-1:0]      first_gap,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cdt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdt_pkg::CFG_W-1:0]      cfg_data
);

    import cdt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MARK  = 3'd1;
    localparam logic [2:0] S_QUERY = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [IMG_W-1:0]    image_size_reg;
    logic [ADDR_W-1:0]   staging_base_reg;
    logic [IDX_W-1:0]    req_idx_reg, req_idx_next;
    logic [MAP_AW-1:0]   chk_byte_reg, chk_byte_next;
    logic [MAP_BYTES-1:0] map_valid_reg;
    logic                rd_valid_reg;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic                res_received_reg, res_received_next;
    logic                res_found_reg, res_found_next;
    logic [IDX_W-1:0]    res_next_reg, res_next_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [ADDR_W-1:0]   out_addr_reg;
    logic                out_received_reg;
    logic                out_found_reg;
    logic [IDX_W-1:0]    out_next_reg;
    logic                out_load;

    logic                accept;
    logic                size_ok;
    logic [IMG_W:0]      chunk_raw;
    logic [CNT_W-1:0]    chunk_count;
    logic [CNT_W-1:0]    last_chunk;
    logic [MAP_AW-1:0]   last_byte;

    logic                ram_wr_en;
    logic [MAP_AW-1:0]   ram_wr_addr;
    logic [BYTE_W-1:0]   ram_wr_data;
    logic                ram_rd_en;
    logic [MAP_AW-1:0]   ram_rd_addr;
    logic [BYTE_W-1:0]   ram_rd_data;
    logic [BYTE_W-1:0]   map_byte;

    logic [BYTE_W-1:0]   scan_missing;
    logic                scan_hit;
    logic [BIT_W-1:0]    scan_pos;

    cdt_map_ram #(
        .AW (MAP_AW),
        .DW (BYTE_W)
    ) u_map_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Chunk count is the image size rounded up to whole chunks, clamped to the bitmap.
    assign size_ok   = (image_size_reg != '0) && (32'(image_size_reg) <= MAX_IMAGE_BYTES);
    assign chunk_raw = {1'b0, image_size_reg} + (IMG_W + 1)'(CHUNK_BYTES - 1);

    always_comb
    begin
        if (32'(chunk_raw >> CHUNK_SHIFT) > MAX_CHUNKS)
        begin
            chunk_count = CNT_W'(MAX_CHUNKS);
        end
        else
        begin
            chunk_count = CNT_W'(chunk_raw >> CHUNK_SHIFT);
        end
    end

    assign last_chunk = chunk_count - CNT_W'(1);
    assign last_byte  = last_chunk[BIT_W +: MAP_AW];

    // A byte that has never been written since reset reads as all zeros.
    assign map_byte = rd_valid_reg ? ram_rd_data : '0;

    // Chunks beyond the image in the last byte count as received during a scan.
    always_comb
    begin
        scan_missing = '0;
        scan_hit     = 1'b0;
        scan_pos     = '0;
        for (int n = 0; n < BYTE_W; n++)
        begin
            if (({1'b0, chk_byte_reg, BIT_W'(n)} < chunk_count) && !map_byte[n])
            begin
                scan_missing[n] = 1'b1;
            end
        end
        for (int n = BYTE_W - 1; n >= 0; n--)
        begin
            if (scan_missing[n])
            begin
                scan_hit = 1'b1;
                scan_pos = BIT_W'(n);
            end
        end
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next        = state_reg;
        req_idx_next      = req_idx_reg;
        chk_byte_next     = chk_byte_reg;
        res_status_next   = res_status_reg;
        res_addr_next     = res_addr_reg;
        res_received_next = res_received_reg;
        res_found_next    = res_found_reg;
        res_next_next     = res_next_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = '0;
        ram_wr_data       = '0;
        ram_rd_en         = 1'b0;
        ram_rd_addr       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_idx_next      = chunk_id;
                    res_status_next   = STATUS_OK;
                    res_addr_next     = '0;
                    res_received_next = 1'b0;
                    res_found_next    = 1'b0;
                    res_next_next     = '0;
                    state_next        = S_DONE;
                    if (kind == KIND_RESTORE)
                    begin
                        if (32'(byte_index) < MAP_BYTES)
                        begin
                            ram_wr_en   = 1'b1;
                            ram_wr_addr = MAP_AW'(byte_index);
                            ram_wr_data = byte_value;
                        end
                        else
                        begin
                            res_status_next = STATUS_INDEX;
                        end
                    end
                    else if (!size_ok)
                    begin
                        res_status_next = STATUS_SIZE;
                    end
                    else
                    begin
                        case (kind)
                            KIND_MARK:
                            begin
                                if (length == '0)
                                begin
                                    res_status_next = STATUS_PARAM;
                                end
                                else if (CNT_W'(chunk_id) >= chunk_count)
                                begin
                                    res_status_next = STATUS_INDEX;
                                end
                                else if (32'(length) > CHUNK_BYTES)
                                begin
                                    res_status_next = STATUS_PARAM;
                                end
                                else
                                begin
                                    res_addr_next = staging_base_reg
                                                  + (ADDR_W'(chunk_id) << CHUNK_SHIFT);
                                    ram_rd_en     = 1'b1;
                                    ram_rd_addr   = chunk_id[BIT_W +: MAP_AW];
                                    state_next    = S_MARK;
                                end
                            end
                            KIND_QUERY:
                            begin
                                if (CNT_W'(chunk_id) >= chunk_count)
                                begin
                                    res_status_next = STATUS_INDEX;
                                end
                                else
                                begin
                                    ram_rd_en   = 1'b1;
                                    ram_rd_addr = chunk_id[BIT_W +: MAP_AW];
                                    state_next  = S_QUERY;
                                end
                            end
                            default:
                            begin
                                ram_rd_en     = 1'b1;
                                ram_rd_addr   = '0;
                                chk_byte_next = '0;
                                state_next    = S_SCAN;
                            end
                        endcase
                    end
                end
            end
            S_MARK:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = req_idx_reg[BIT_W +: MAP_AW];
                ram_wr_data = map_byte | (BYTE_W'(1) << req_idx_reg[BIT_W-1:0]);
                state_next  = S_DONE;
            end
            S_QUERY:
            begin
                res_received_next = map_byte[req_idx_reg[BIT_W-1:0]];
                state_next        = S_DONE;
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    res_found_next = 1'b1;
                    res_next_next  = IDX_W'({chk_byte_reg, scan_pos});
                    state_next     = S_DONE;
                end
                else if (chk_byte_reg == last_byte)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    // Fetch the following byte while this one is examined.
                    ram_rd_en     = 1'b1;
                    ram_rd_addr   = chk_byte_reg + MAP_AW'(1);
                    chk_byte_next = chk_byte_reg + MAP_AW'(1);
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            out_valid_reg    <= 1'b0;
            image_size_reg   <= '0;
            staging_base_reg <= '0;
            map_valid_reg    <= '0;
            rd_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IMAGE_SIZE:   image_size_reg   <= cfg_data[IMG_W-1:0];
                    CFG_STAGING_BASE: staging_base_reg <= cfg_data[ADDR_W-1:0];
                    default:          ;
                endcase
            end
            if (ram_wr_en)
            begin
                map_valid_reg[ram_wr_addr] <= 1'b1;
            end
            if (ram_rd_en)
            begin
                rd_valid_reg <= map_valid_reg[ram_rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_idx_reg      <= req_idx_next;
        chk_byte_reg     <= chk_byte_next;
        res_status_reg   <= res_status_next;
        res_addr_reg     <= res_addr_next;
        res_received_reg <= res_received_next;
        res_found_reg    <= res_found_next;
        res_next_reg     <= res_next_next;
        if (out_load)
        begin
            out_status_reg   <= res_status_reg;
            out_addr_reg     <= res_addr_reg;
            out_received_reg <= res_received_reg;
            out_found_reg    <= res_found_reg;
            out_next_reg     <= res_next_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign write_address = out_addr_reg;
    assign received      = out_received_reg;
    assign found         = out_found_reg;
    assign first_gap     = out_next_reg;

endmodule

/* sim/tb_chunk_download_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk download tracker testbench
// Sends mark, query, scan and restore requests with random gaps on both
// channels. A scoreboard keeps its own bitmap and register copies, predicts
// the result of every accepted request and checks each result transfer
// field by field, in order.
// ----------------------------------------------------------------------------
module tb_chunk_download_tracker;
    import cdt_pkg::*;

    localparam int ITEM_TARGET = 1450;
    localparam int STALL_LIMIT = 4000;
    localparam int LONG_HOLD   = 400;
    localparam int TAIL_CYCLES = 160;
    localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
        logic [LEN_W-1:0]  len;
        logic [BIDX_W-1:0] bidx;
        logic [BYTE_W-1:0] bval;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic                rcv;
        logic                found;
        logic [IDX_W-1:0]    next;
    } result_t;

    class chunk_map_scoreboard;
        logic [BYTE_W-1:0] chunk_bits [MAP_BYTES] = '{default: '0};
        logic [IMG_W-1:0]  image_bytes = '0;
        logic [ADDR_W-1:0] base_addr = '0;
        result_t           expected_results [$];
        int                errors = 0;

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
            if (index == CFG_IMAGE_SIZE)
                image_bytes = data[IMG_W-1:0];
            else
                base_addr = data[ADDR_W-1:0];
        endfunction

        function bit size_valid();
            return image_bytes != 0 && image_bytes <= MAX_IMAGE_BYTES;
        endfunction

        function int chunk_count();
            int n;
            n = (int'(image_bytes) + CHUNK_BYTES - 1) / CHUNK_BYTES;
            return (n > MAX_CHUNKS) ? MAX_CHUNKS : n;
        endfunction

        function logic chunk_received(logic [IDX_W-1:0] i);
            return chunk_bits[i[IDX_W-1:BIT_W]][i[BIT_W-1:0]];
        endfunction

        // Works out the result of one accepted request and updates the bitmap.
        function void note_request(request_t req);
            result_t res;
            int      count;
            int      i;
            res = '0;
            count = chunk_count();
            if (req.kind == KIND_RESTORE)
            begin
                if (req.bidx < MAP_BYTES)
                    chunk_bits[req.bidx] = req.bval;
                else
                    res.status = STATUS_INDEX;
            end
            else if (!size_valid())
                res.status = STATUS_SIZE;
            else if (req.kind == KIND_MARK)
            begin
                if (req.len == 0)
                    res.status = STATUS_PARAM;
                else if (req.idx >= count)
                    res.status = STATUS_INDEX;
                else if (req.len > CHUNK_BYTES)
                    res.status = STATUS_PARAM;
                else
                begin
                    res.addr = base_addr + ADDR_W'(req.idx) * ADDR_W'(CHUNK_BYTES);
                    chunk_bits[req.idx[IDX_W-1:BIT_W]][req.idx[BIT_W-1:0]] = 1'b1;
                end
            end
            else if (req.kind == KIND_QUERY)
            begin
                if (req.idx >= count)
                    res.status = STATUS_INDEX;
                else
                    res.rcv = chunk_received(req.idx);
            end
            else
            begin
                for (i = 0; i < count; i++)
                begin
                    if (!chunk_received(IDX_W'(i)))
                    begin
                        res.found = 1'b1;
                        res.next  = IDX_W'(i);
                        break;
                    end
                end
            end
            expected_results.push_back(res);
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %0h", $time, got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            check_field("status", want.status, got.status);
            check_field("write_address", want.addr, got.addr);
            check_field("received", want.rcv, got.rcv);
            check_field("found", want.found, got.found);
            check_field("first_gap", want.next, got.next);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [KIND_W-1:0]    kind = '0;
    logic [IDX_W-1:0]     chunk_id = '0;
    logic [LEN_W-1:0]     length = '0;
    logic [BIDX_W-1:0]    byte_index = '0;
    logic [BYTE_W-1:0]    byte_value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [ADDR_W-1:0]    write_address;
    logic                 received;
    logic                 found;
    logic [IDX_W-1:0]     first_gap;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    chunk_map_scoreboard sb = new();
    bit tx_idle = 1'b1;
    bit rx_idle = 1'b1;
    int rx_hold = 0;
    int sent = 0;
    int quiet_cycles = 0;

    chunk_download_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .chunk_id      (chunk_id),
        .length        (length),
        .byte_index    (byte_index),
        .byte_value    (byte_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .write_address (write_address),
        .received      (received),
        .found         (found),
        .first_gap     (first_gap),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("tb_chunk_download_tracker: FAIL");
            $finish;
        end
    end

    // Valid is only lowered when a gap is drawn, so back-to-back requests
    // keep it high across the transfer edge.
    task automatic send_request(logic [KIND_W-1:0] k, logic [IDX_W-1:0] idx,
                                logic [LEN_W-1:0] len, logic [BIDX_W-1:0] bidx,
                                logic [BYTE_W-1:0] bval);
        int gap;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= k;
        chunk_id    <= idx;
        length      <= len;
        byte_index  <= bidx;
        byte_value  <= bval;
        do @(posedge clk); while (!in_ready);
        sb.note_request({k, idx, len, bidx, bval});
        sent++;
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (sb.expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(index, data);
    endtask

    task automatic configure(int unsigned size_bytes, int unsigned base);
        wait_all_results();
        if ($urandom_range(0, 1))
        begin
            write_reg(CFG_IMAGE_SIZE, CFG_W'(size_bytes));
            write_reg(CFG_STAGING_BASE, CFG_W'(base));
        end
        else
        begin
            write_reg(CFG_STAGING_BASE, CFG_W'(base));
            write_reg(CFG_IMAGE_SIZE, CFG_W'(size_bytes));
        end
        cfg_valid <= 1'b0;
    endtask

    // Restores every used bitmap byte as full, bar at most one random byte,
    // then scans, so that scans reach the far end of the image.
    task automatic fill_bitmap(int count);
        int nbytes;
        int hole;
        int b;
        nbytes = (count + 7) / 8;
        hole = $urandom_range(0, nbytes);
        for (b = 0; b < nbytes; b++)
            send_request(KIND_RESTORE, IDX_W'($urandom), LEN_W'($urandom), BIDX_W'(b),
                         (b == hole) ? BYTE_W'($urandom) : 8'hFF);
        send_request(KIND_SCAN, IDX_W'($urandom), LEN_W'($urandom), BIDX_W'($urandom),
                     BYTE_W'($urandom));
    endtask

    task automatic send_random(int count);
        logic [KIND_W-1:0] k;
        logic [IDX_W-1:0]  idx;
        logic [LEN_W-1:0]  len;
        logic [BIDX_W-1:0] bidx;
        logic [BYTE_W-1:0] bval;
        int                pick;
        int                top;
        top  = (count > 0) ? count - 1 : MAX_CHUNKS - 1;
        idx  = IDX_W'($urandom_range(0, top));
        len  = LEN_W'($urandom_range(1, CHUNK_BYTES));
        bidx = BIDX_W'($urandom_range(0, top / 8));
        bval = $urandom_range(0, 1) ? 8'hFF : BYTE_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 6)
            len = LEN_W'(CHUNK_BYTES + pick % 3 - 1);
        if (pick < 30)
            k = KIND_MARK;
        else if (pick < 45)
        begin
            k = KIND_QUERY;
            if (pick >= 42)
                idx = IDX_W'(count);
        end
        else if (pick < 60)
            k = KIND_SCAN;
        else if (pick < 75)
            k = KIND_RESTORE;
        else
        begin
            k    = KIND_W'($urandom);
            idx  = IDX_W'($urandom);
            len  = LEN_W'($urandom);
            bidx = BIDX_W'($urandom);
            bval = BYTE_W'($urandom);
        end
        send_request(k, idx, len, bidx, bval);
    endtask

    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold > 0)
            begin
                stall = rx_hold;
                rx_hold = 0;
            end
            else
                stall = rx_idle ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result({status, write_address, received, found, first_gap});
        end
    end

    initial
    begin : stimulus
        int          phase;
        int          count;
        int          n_items;
        int          j;
        int unsigned size_bytes;
        int unsigned base;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Image size is zero after reset: only restore is honoured.
        send_request(KIND_SCAN, 0, 0, 0, 0);
        send_request(KIND_MARK, 0, 1, 0, 0);
        send_request(KIND_QUERY, 0, 0, 0, 0);
        send_request(KIND_RESTORE, 0, 0, 0, 8'hA5);
        send_request(KIND_RESTORE, 0, 0, 7'h7F, 8'hFF);

        // Single chunk image, staging base at the top of the address space.
        configure(1, 32'(ADDR_MAX));
        send_request(KIND_SCAN, 0, 0, 0, 0);
        send_request(KIND_QUERY, 0, 0, 0, 0);
        send_request(KIND_QUERY, 1, 0, 0, 0);
        send_request(KIND_MARK, 10'h3FF, 0, 0, 0);
        send_request(KIND_MARK, 1, LEN_W'(CHUNK_BYTES), 0, 0);
        send_request(KIND_MARK, 0, LEN_W'(CHUNK_BYTES + 1), 0, 0);
        send_request(KIND_MARK, 0, 16'hFFFF, 0, 0);
        send_request(KIND_MARK, 0, LEN_W'(CHUNK_BYTES), 0, 0);
        send_request(KIND_RESTORE, 0, 0, 0, 8'h00);
        send_request(KIND_SCAN, 0, 0, 0, 0);
        send_request(KIND_MARK, 0, 1, 0, 0);
        send_request(KIND_SCAN, 0, 0, 0, 0);

        // Largest image: address wraps and the last chunk is reachable.
        configure(MAX_IMAGE_BYTES, 32'h1FFF00);
        send_request(KIND_SCAN, 0, 0, 0, 0);
        send_request(KIND_QUERY, 10'h3FF, 0, 0, 0);
        send_request(KIND_MARK, 10'h3FF, LEN_W'(CHUNK_BYTES), 0, 0);

        configure(MAX_IMAGE_BYTES + 1, 0);
        send_request(KIND_SCAN, 0, 0, 0, 0);
        configure(2 ** IMG_W - 1, 0);
        send_request(KIND_MARK, 0, 1, 0, 0);

        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0: size_bytes = 0;
                1: size_bytes = $urandom_range(MAX_IMAGE_BYTES + 1, 2 ** IMG_W - 1);
                2: size_bytes = MAX_IMAGE_BYTES;
                3, 4, 5: size_bytes = $urandom_range(1, 4096);
                6, 7: size_bytes = $urandom_range(4097, 65536);
                8: size_bytes = $urandom_range(65537, MAX_IMAGE_BYTES);
                default: size_bytes = $urandom_range(1, MAX_CHUNKS) * CHUNK_BYTES
                                      + $urandom_range(0, 1);
            endcase
            case ($urandom_range(0, 3))
                0: base = 0;
                1: base = 32'(ADDR_MAX);
                default: base = $urandom_range(0, 2 ** ADDR_W - 1);
            endcase
            configure(size_bytes, base);
            count   = sb.chunk_count();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            n_items = sb.size_valid() ? $urandom_range(30, 100) : $urandom_range(10, 30);
            // Hold the receiver off for a long stretch while the sender keeps
            // offering back-to-back requests, so the input side stalls.
            if (phase == 1)
            begin
                tx_idle = 1'b0;
                rx_hold = LONG_HOLD;
            end
            if (sb.size_valid() && $urandom_range(0, (count <= 256) ? 1 : 5) == 0)
                fill_bitmap(count);
            for (j = 0; j < n_items && sent < ITEM_TARGET; j++)
            begin
                if ($urandom_range(0, 199) == 0)
                    wait_all_results();
                send_random(count);
            end
            phase++;
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_chunk_download_tracker: PASS");
        else
            $display("tb_chunk_download_tracker: FAIL");
        $finish;
    end

endmodule
